### rtl/core/pwft_pkg.sv
package pwft_pkg;

  // Width of a length-delimited payload count; longer lengths are rejected.
  localparam int LENGTH_BITS      = 32;
  // Longest varint that is accepted, in bytes.
  localparam int VARINT_MAX_BYTES = 10;

  // Wire types taken from the low three key bits.
  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LENGTH  = 3'd2;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;

  // Payload byte counts of the fixed-width wire types.
  localparam int FIXED64_BYTES = 8;
  localparam int FIXED32_BYTES = 4;

  // Result kinds.
  localparam logic [1:0] EV_VARINT  = 2'd0;
  localparam logic [1:0] EV_LENGTH  = 2'd1;
  localparam logic [1:0] EV_PAYLOAD = 2'd2;
  localparam logic [1:0] EV_ERROR   = 2'd3;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_VARINT_LEN = 3'd1;
  localparam logic [2:0] ERR_FIELD_ZERO = 3'd2;
  localparam logic [2:0] ERR_WIRE_TYPE  = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_last;
  } in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [31:0] field_number;
    logic [2:0]  wire_kind;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic        field_done;
    logic        message_end;
    logic [2:0]  error_code;
  } out_t;

  // Handshake between the pipeline shell and the decoder.
  typedef struct packed {
    logic step;       // decoder consumes the staged byte this cycle
  } step_ctl_t;

  typedef struct packed {
    logic res_valid;  // the consumed byte produces a result
  } step_sts_t;

endpackage

### rtl/core/pwft_decoder.sv
module pwft_decoder (
  input  logic              clk,
  input  logic              rst,
  input  pwft_pkg::step_ctl_t ctl,
  input  pwft_pkg::in_t     item,
  output pwft_pkg::step_sts_t sts,
  output pwft_pkg::out_t    res
);
  import pwft_pkg::*;

  typedef enum logic [1:0] {
    PH_KEY,
    PH_VALUE,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_t;

  phase_t                 phase, phase_next;
  logic [63:0]            acc, acc_next;
  logic [3:0]             cnt, cnt_next;
  logic [31:0]            cur_field, cur_field_next;
  logic [2:0]             cur_wire, cur_wire_next;
  logic [LENGTH_BITS-1:0] rem, rem_next;
  logic                   skipping, skipping_next;

  logic [5:0]             shamt;
  logic [63:0]            acc_sum;
  logic [3:0]             cnt_inc;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   do_fail;
  logic [2:0]             fail_code;
  logic                   last;

  assign last    = item.message_last;
  assign shamt   = 6'({cnt, 3'b000} - {3'b000, cnt});
  assign acc_sum = acc | ({57'd0, item.data_byte[6:0]} << shamt);
  assign cnt_inc = cnt + 4'd1;
  assign rem_dec = (rem != '0) ? rem - LENGTH_BITS'(1) : rem;

  always_comb begin
    phase_next     = phase;
    acc_next       = acc;
    cnt_next       = cnt;
    cur_field_next = cur_field;
    cur_wire_next  = cur_wire;
    rem_next       = rem;
    skipping_next  = skipping;
    do_fail        = 1'b0;
    fail_code      = ERR_NONE;
    sts.res_valid  = 1'b0;
    res            = '0;

    if (skipping) begin
      if (last) begin
        skipping_next = 1'b0;
        phase_next    = PH_KEY;
        acc_next      = '0;
        cnt_next      = '0;
        rem_next      = '0;
      end
    end else if (phase == PH_PAYLOAD) begin
      rem_next = rem_dec;
      if (rem_dec == '0) begin
        phase_next       = PH_KEY;
        sts.res_valid    = 1'b1;
        res.event_kind   = EV_PAYLOAD;
        res.payload_byte = item.data_byte;
        res.field_done   = 1'b1;
        res.message_end  = last;
      end else if (last) begin
        do_fail   = 1'b1;
        fail_code = ERR_TRUNCATED;
      end else begin
        sts.res_valid    = 1'b1;
        res.event_kind   = EV_PAYLOAD;
        res.payload_byte = item.data_byte;
      end
    end else begin
      acc_next = acc_sum;
      cnt_next = cnt_inc;
      if (item.data_byte[7]) begin
        if (cnt_inc >= 4'(VARINT_MAX_BYTES)) begin
          do_fail   = 1'b1;
          fail_code = ERR_VARINT_LEN;
        end else if (last) begin
          do_fail   = 1'b1;
          fail_code = ERR_TRUNCATED;
        end
      end else begin
        acc_next = '0;
        cnt_next = '0;
        case (phase)
          PH_VALUE: begin
            phase_next      = PH_KEY;
            sts.res_valid   = 1'b1;
            res.event_kind  = EV_VARINT;
            res.field_value = acc_sum;
            res.field_done  = 1'b1;
            res.message_end = last;
          end
          PH_LENGTH: begin
            if ((acc_sum >> LENGTH_BITS) != 64'd0) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNCATED;
            end else if (acc_sum == 64'd0) begin
              phase_next      = PH_KEY;
              sts.res_valid   = 1'b1;
              res.event_kind  = EV_LENGTH;
              res.field_done  = 1'b1;
              res.message_end = last;
            end else if (last) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNCATED;
            end else begin
              rem_next        = acc_sum[LENGTH_BITS-1:0];
              phase_next      = PH_PAYLOAD;
              sts.res_valid   = 1'b1;
              res.event_kind  = EV_LENGTH;
              res.field_value = acc_sum;
            end
          end
          default: begin
            // Key byte completes: latch field number and wire type, then check.
            phase_next     = PH_KEY;
            cur_field_next = acc_sum[34:3];
            cur_wire_next  = acc_sum[2:0];
            if (acc_sum[34:3] == 32'd0) begin
              do_fail   = 1'b1;
              fail_code = ERR_FIELD_ZERO;
            end else if (acc_sum[2:0] != WIRE_VARINT && acc_sum[2:0] != WIRE_FIXED64 &&
                         acc_sum[2:0] != WIRE_LENGTH && acc_sum[2:0] != WIRE_FIXED32) begin
              do_fail   = 1'b1;
              fail_code = ERR_WIRE_TYPE;
            end else if (last) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNCATED;
            end else if (acc_sum[2:0] == WIRE_VARINT) begin
              phase_next = PH_VALUE;
            end else if (acc_sum[2:0] == WIRE_LENGTH) begin
              phase_next = PH_LENGTH;
            end else begin
              rem_next   = (acc_sum[2:0] == WIRE_FIXED64) ? LENGTH_BITS'(FIXED64_BYTES)
                                                          : LENGTH_BITS'(FIXED32_BYTES);
              phase_next = PH_PAYLOAD;
            end
          end
        endcase
      end
    end

    if (do_fail) begin
      phase_next      = PH_KEY;
      acc_next        = '0;
      cnt_next        = '0;
      rem_next        = '0;
      skipping_next   = !last;
      sts.res_valid   = 1'b1;
      res             = '0;
      res.event_kind  = EV_ERROR;
      res.message_end = last;
      res.error_code  = fail_code;
    end

    // Every result reports the field as it stands after this byte.
    res.field_number = cur_field_next;
    res.wire_kind    = cur_wire_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_KEY;
      acc       <= '0;
      cnt       <= '0;
      cur_field <= '0;
      cur_wire  <= '0;
      rem       <= '0;
      skipping  <= 1'b0;
    end else if (ctl.step) begin
      phase     <= phase_next;
      acc       <= acc_next;
      cnt       <= cnt_next;
      cur_field <= cur_field_next;
      cur_wire  <= cur_wire_next;
      rem       <= rem_next;
      skipping  <= skipping_next;
    end
  end

  a_err_starts_skip: assert property (@(posedge clk) disable iff (rst)
    ctl.step && sts.res_valid && res.event_kind == EV_ERROR && !last |=> skipping)
    else $error("error before the message end did not start skipping");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    ctl.step && skipping |-> !sts.res_valid)
    else $error("result produced while skipping");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> rem != '0)
    else $error("payload phase with no bytes remaining");

  a_varint_count: assert property (@(posedge clk) disable iff (rst)
    cnt < 4'(VARINT_MAX_BYTES))
    else $error("varint byte count out of range");

  a_end_resyncs: assert property (@(posedge clk) disable iff (rst)
    ctl.step && sts.res_valid && res.message_end |=> phase == PH_KEY && !skipping && cnt == '0)
    else $error("message end did not return to key reading");

endmodule

### rtl/core/protobuf_wire_field_tokenizer.sv
// Channel   Direction  Payload  Handshake
// in        input      in_t     in_valid / in_stall, transfer when valid and not stall
// out       output     out_t    out_valid / out_stall, transfer when valid and not stall
//
// One byte is taken per cycle unless a stalled result holds the pipe; a result passes
// through the input register, the combinational decoder and the result register.
// Reset is synchronous and active high; it empties both registers and puts the
// decoder back to reading a key with no skip pending.
// A stalled result holds the pipe: the input register drains only when the result
// register is empty or its result is being transferred in the same cycle.
module protobuf_wire_field_tokenizer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pwft_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pwft_pkg::out_t out_data
);
  import pwft_pkg::*;

  // Input register: holds one byte until the decoder can consume it.
  logic      stage_valid;
  in_t       stage_data;

  // The decoder consumes the staged byte whenever the result register can take
  // whatever that byte produces. Bytes that produce nothing advance the same way.
  logic      advance;
  step_ctl_t ctl;
  step_sts_t sts;
  out_t      res;

  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;
  assign ctl.step = advance;

  pwft_decoder u_decoder (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .item (stage_data),
    .sts  (sts),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stage_data <= in_data;
    end
  end

  // Result register: a new result replaces the old one only once it has been
  // transferred, so a stalled payload stays put.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= sts.res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && sts.res_valid) begin
      out_data <= res;
    end
  end

endmodule
